FILE: hw/rtl/ptws_pkg.sv
package ptws_pkg;

  // Tile table geometry.
  localparam int unsigned MaxTiles  = 32;
  localparam int unsigned TileIdxW  = $clog2(MaxTiles);
  localparam int unsigned CoordW    = 64;
  localparam int unsigned EntryW    = 2 * CoordW + 1;

  // Configuration registers.
  localparam int unsigned PadW      = 32;
  localparam int unsigned TiuW      = 6;
  localparam int unsigned CfgAddrW  = 1;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [CfgAddrW-1:0] CFG_PADDING      = 1'b0;
  localparam logic [CfgAddrW-1:0] CFG_TILES_IN_USE = 1'b1;

  localparam logic [TiuW-1:0] TiuReset = TiuW'(MaxTiles);

  // Request kinds carried on the input tuser bit.
  localparam logic MODE_WRITE    = 1'b0;
  localparam logic MODE_TERMINAL = 1'b1;

  // Stream widths, rounded up to whole bytes.
  localparam int unsigned InDataW  = ((TileIdxW + 2 * CoordW + 1 + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((TileIdxW + 7) / 8) * 8;

  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  // One tile table entry.
  typedef struct packed {
    logic                     located;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } tile_entry_t;

endpackage

FILE: hw/rtl/ptws_ram.sv
module ptws_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/padded_tile_window_select_core.sv
// Padded bounding-box tile selection.
// The input stream carries two kinds of request, told apart by tuser: a table
// write stores the x, y and located flag of one tile, and a terminal names
// the tile that owns a query terminal; tlast marks the final terminal.
// Located terminals widen a box, unlocated ones raise a spill flag. After the
// final terminal the box is padded by the padding register with saturation,
// the tiles in use are scanned in ascending order and every located tile
// inside the box is sent on the output stream, followed by the last tile in
// use when spill was raised. tlast marks the last result; tuser flags an
// empty selection or a bad terminal (one result in place of the list).
// An out-of-range terminal sets the bad-terminal flag; any other terminal
// reads its tile from the table, and for a located tile one shared signed
// 65-bit add/compare unit does the four box compares one after another.
// After the final terminal a check step follows. Unless a bad terminal was
// seen, the box is padded and each tile in use read and compared (if a
// located terminal was seen) and the spill tile checked; then the last result
// is handed over. The input is ready only while the block is idle.
// A stalled output holds its result, and the scan waits at the next result
// until it is taken. Reset clears the box, the flags and the output; the tile
// table is not cleared and must be written before its entries are used.
module padded_tile_window_select_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [ptws_pkg::CfgAddrW-1:0]       cfg_addr_i,
  input  logic [ptws_pkg::CfgDataW-1:0]       cfg_data_i,
  // Request stream.
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tile_index[4:0], coord_x[68:5], coord_y[132:69], located[133], zeros.
  input  logic [ptws_pkg::InDataW-1:0]        s_axis_tdata_i,
  // mode[0].
  input  logic                                s_axis_tuser_i,
  // final_terminal.
  input  logic                                s_axis_tlast_i,
  // Result stream.
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // selected_tile[4:0], zeros.
  output logic [ptws_pkg::OutDataW-1:0]       m_axis_tdata_o,
  // empty_selection[0], bad_terminal[1].
  output logic [1:0]                          m_axis_tuser_o,
  // end_of_list.
  output logic                                m_axis_tlast_o
);

  localparam int unsigned IdxW = ptws_pkg::TileIdxW;
  localparam int unsigned CW   = ptws_pkg::CoordW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TERM,
    S_CHECK,
    S_PAD,
    S_SREAD,
    S_SCMP,
    S_HIT,
    S_SPILL,
    S_LAST
  } state_e;

  // Input field unpacking.
  logic [IdxW-1:0]       in_idx;
  ptws_pkg::tile_entry_t in_entry;

  assign in_idx           = s_axis_tdata_i[IdxW-1:0];
  assign in_entry.x       = s_axis_tdata_i[IdxW +: CW];
  assign in_entry.y       = s_axis_tdata_i[IdxW + CW +: CW];
  assign in_entry.located = s_axis_tdata_i[IdxW + 2 * CW];

  // Registers.
  state_e                     state_q, state_d;
  logic [1:0]                 step_q, step_d;
  logic [IdxW-1:0]            addr_q, addr_d;
  logic                       final_q, final_d;
  logic signed [CW-1:0]       min_x_q, min_x_d, min_y_q, min_y_d;
  logic signed [CW-1:0]       max_x_q, max_x_d, max_y_q, max_y_d;
  logic                       any_q, any_d, spill_q, spill_d, err_q, err_d;
  logic                       hit_q, hit_d;
  logic                       pend_q, pend_d;
  logic [IdxW-1:0]            pend_tile_q, pend_tile_d;
  logic [ptws_pkg::PadW-1:0]  pad_q;
  logic [ptws_pkg::TiuW-1:0]  tiu_q;
  logic                       out_valid_q, out_valid_d;
  logic [IdxW-1:0]            out_tile_q, out_tile_d;
  logic                       out_last_q, out_last_d;
  logic                       out_empty_q, out_empty_d;
  logic                       out_bad_q, out_bad_d;

  // Last tile in use, with the register value clamped to the table.
  logic [IdxW-1:0] n_last;

  always_comb begin
    if (tiu_q == '0) begin
      n_last = '0;
    end else if (tiu_q > ptws_pkg::TiuW'(ptws_pkg::MaxTiles)) begin
      n_last = IdxW'(ptws_pkg::MaxTiles - 1);
    end else begin
      n_last = IdxW'(tiu_q - 1'b1);
    end
  end

  // Tile table.
  logic                  ram_we;
  logic [IdxW-1:0]       ram_raddr;
  ptws_pkg::tile_entry_t rd_entry;

  assign ram_raddr = (state_q == S_IDLE) ? in_idx : addr_q;

  ptws_ram #(
    .Width (ptws_pkg::EntryW),
    .Depth (ptws_pkg::MaxTiles)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_idx),
    .wdata_i (in_entry),
    .raddr_i (ram_raddr),
    .rdata_o (rd_entry)
  );

  // Shared adder: a - b for compares and lower padding, a + pad for upper padding.
  logic signed [CW-1:0] op_a;
  logic [CW:0]          op_b;
  logic                 op_sub;
  logic [CW:0]          sum;
  logic                 lt;
  logic signed [CW-1:0] sat;

  always_comb begin
    if (state_q == S_PAD) begin
      op_sub = (step_q < 2'd2);
      op_b   = {{(CW + 1 - ptws_pkg::PadW){1'b0}}, pad_q};
      case (step_q)
        2'd0:    op_a = min_x_q;
        2'd1:    op_a = min_y_q;
        2'd2:    op_a = max_x_q;
        default: op_a = max_y_q;
      endcase
    end else begin
      op_sub = 1'b1;
      case (step_q)
        2'd0: begin
          op_a = rd_entry.x;
          op_b = {min_x_q[CW-1], min_x_q};
        end
        2'd1: begin
          op_a = rd_entry.y;
          op_b = {min_y_q[CW-1], min_y_q};
        end
        2'd2: begin
          op_a = max_x_q;
          op_b = {rd_entry.x[CW-1], rd_entry.x};
        end
        default: begin
          op_a = max_y_q;
          op_b = {rd_entry.y[CW-1], rd_entry.y};
        end
      endcase
    end
    sum = {op_a[CW-1], op_a} + (op_sub ? ~op_b : op_b) + {{CW{1'b0}}, op_sub};
    lt  = sum[CW];
    if (sum[CW] != sum[CW-1]) begin
      sat = sum[CW] ? ptws_pkg::CoordMin : ptws_pkg::CoordMax;
    end else begin
      sat = sum[CW-1:0];
    end
  end

  logic out_free;
  logic spill_extra;

  assign out_free    = !out_valid_q || m_axis_tready_i;
  assign spill_extra = spill_q && !(pend_q && (pend_tile_q == n_last));

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    addr_d      = addr_q;
    final_d     = final_q;
    min_x_d     = min_x_q;
    min_y_d     = min_y_q;
    max_x_d     = max_x_q;
    max_y_d     = max_y_q;
    any_d       = any_q;
    spill_d     = spill_q;
    err_d       = err_q;
    hit_d       = hit_q;
    pend_d      = pend_q;
    pend_tile_d = pend_tile_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_tile_d  = out_tile_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;
    out_bad_d   = out_bad_q;
    ram_we      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          if (s_axis_tuser_i == ptws_pkg::MODE_WRITE) begin
            ram_we = 1'b1;
          end else begin
            addr_d  = in_idx;
            final_d = s_axis_tlast_i;
            step_d  = 2'd0;
            if (in_idx > n_last) begin
              err_d   = 1'b1;
              state_d = s_axis_tlast_i ? S_CHECK : S_IDLE;
            end else begin
              state_d = S_TERM;
            end
          end
        end
      end

      S_TERM: begin
        if (step_q == 2'd0 && !rd_entry.located) begin
          spill_d = 1'b1;
          state_d = final_q ? S_CHECK : S_IDLE;
        end else begin
          any_d = 1'b1;
          if (lt) begin
            case (step_q)
              2'd0:    min_x_d = rd_entry.x;
              2'd1:    min_y_d = rd_entry.y;
              2'd2:    max_x_d = rd_entry.x;
              default: max_y_d = rd_entry.y;
            endcase
          end
          step_d = step_q + 2'd1;
          if (step_q == 2'd3) begin
            state_d = final_q ? S_CHECK : S_IDLE;
          end
        end
      end

      S_CHECK: begin
        step_d = 2'd0;
        if (err_q) begin
          state_d = S_LAST;
        end else if (any_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_SPILL;
        end
      end

      S_PAD: begin
        case (step_q)
          2'd0:    min_x_d = sat;
          2'd1:    min_y_d = sat;
          2'd2:    max_x_d = sat;
          default: max_y_d = sat;
        endcase
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          addr_d  = '0;
          state_d = S_SREAD;
        end
      end

      S_SREAD: begin
        step_d  = 2'd0;
        state_d = S_SCMP;
      end

      S_SCMP: begin
        // The window test is four "not below the bound" checks in a row.
        hit_d  = ((step_q == 2'd0) ? rd_entry.located : hit_q) && !lt;
        step_d = step_q + 2'd1;
        if (step_q == 2'd3) begin
          if (hit_q && !lt) begin
            state_d = S_HIT;
          end else if (addr_q == n_last) begin
            state_d = S_SPILL;
          end else begin
            addr_d  = addr_q + 1'b1;
            state_d = S_SREAD;
          end
        end
      end

      S_HIT: begin
        // A hit is held back until the next one shows it is not the last.
        if (!pend_q || out_free) begin
          if (pend_q) begin
            out_valid_d = 1'b1;
            out_tile_d  = pend_tile_q;
            out_last_d  = 1'b0;
            out_empty_d = 1'b0;
            out_bad_d   = 1'b0;
          end
          pend_d      = 1'b1;
          pend_tile_d = addr_q;
          if (addr_q == n_last) begin
            state_d = S_SPILL;
          end else begin
            addr_d  = addr_q + 1'b1;
            state_d = S_SREAD;
          end
        end
      end

      S_SPILL: begin
        if (!spill_extra) begin
          state_d = S_LAST;
        end else if (!pend_q || out_free) begin
          if (pend_q) begin
            out_valid_d = 1'b1;
            out_tile_d  = pend_tile_q;
            out_last_d  = 1'b0;
            out_empty_d = 1'b0;
            out_bad_d   = 1'b0;
          end
          pend_d      = 1'b1;
          pend_tile_d = n_last;
          state_d     = S_LAST;
        end
      end

      S_LAST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_tile_d  = pend_q ? pend_tile_q : '0;
          out_last_d  = 1'b1;
          out_empty_d = !err_q && !pend_q;
          out_bad_d   = err_q;
          min_x_d     = ptws_pkg::CoordMax;
          min_y_d     = ptws_pkg::CoordMax;
          max_x_d     = ptws_pkg::CoordMin;
          max_y_d     = ptws_pkg::CoordMin;
          any_d       = 1'b0;
          spill_d     = 1'b0;
          err_d       = 1'b0;
          pend_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= 2'd0;
      addr_q      <= '0;
      final_q     <= 1'b0;
      min_x_q     <= ptws_pkg::CoordMax;
      min_y_q     <= ptws_pkg::CoordMax;
      max_x_q     <= ptws_pkg::CoordMin;
      max_y_q     <= ptws_pkg::CoordMin;
      any_q       <= 1'b0;
      spill_q     <= 1'b0;
      err_q       <= 1'b0;
      hit_q       <= 1'b0;
      pend_q      <= 1'b0;
      pend_tile_q <= '0;
      pad_q       <= '0;
      tiu_q       <= ptws_pkg::TiuReset;
      out_valid_q <= 1'b0;
      out_tile_q  <= '0;
      out_last_q  <= 1'b0;
      out_empty_q <= 1'b0;
      out_bad_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      addr_q      <= addr_d;
      final_q     <= final_d;
      min_x_q     <= min_x_d;
      min_y_q     <= min_y_d;
      max_x_q     <= max_x_d;
      max_y_q     <= max_y_d;
      any_q       <= any_d;
      spill_q     <= spill_d;
      err_q       <= err_d;
      hit_q       <= hit_d;
      pend_q      <= pend_d;
      pend_tile_q <= pend_tile_d;
      out_valid_q <= out_valid_d;
      out_tile_q  <= out_tile_d;
      out_last_q  <= out_last_d;
      out_empty_q <= out_empty_d;
      out_bad_q   <= out_bad_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          ptws_pkg::CFG_PADDING:      pad_q <= cfg_data_i[ptws_pkg::PadW-1:0];
          ptws_pkg::CFG_TILES_IN_USE: tiu_q <= cfg_data_i[ptws_pkg::TiuW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(ptws_pkg::OutDataW - IdxW){1'b0}}, out_tile_q};
  assign m_axis_tuser_o  = {out_bad_q, out_empty_q};
  assign m_axis_tlast_o  = out_last_q;

  // A bad-terminal result always stands alone and is never an empty selection.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tlast_o && !m_axis_tuser_o[0])
    else $error("bad terminal result is not a lone final result");

  // The held-back hit is always a tile in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> pend_tile_q <= n_last)
    else $error("pending tile beyond tiles in use");

  // The scan never reads past the last tile in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SREAD || state_q == S_SCMP || state_q == S_HIT) |-> addr_q <= n_last)
    else $error("scan address beyond tiles in use");

  // Handing over the last result clears the query state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAST) && out_free |=>
      (state_q == S_IDLE) && !any_q && !spill_q && !err_q && !pend_q && m_axis_tlast_o)
    else $error("query state not cleared after last result");

  // An error query never runs the window scan.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> !(state_q == S_PAD || state_q == S_SREAD || state_q == S_SCMP))
    else $error("scan started on an errored query");

endmodule
